>>> src/modexp_pkg.sv
package modexp_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REDUCE = 3'b010,
        S_MULT   = 3'b100
    } t_state;

endpackage

>>> src/modular_exponentiation.sv
// Modular exponentiation engine: each transfer on i_start (taken while o_busy is low) returns
// i_cipher_word raised to the exponent register modulo the modulus register, as one result
// on o_plain_word marked by a single-cycle o_done pulse that the receiver must take as it
// comes. An exponent of zero gives 1 and a modulus of zero gives 0, both registered in the cycle
// after the start. Otherwise the base is first reduced bit-serially, then each exponent bit up
// to the highest set one is processed with the multiply and square running side by side over
// the shared square-base shift register, a double and then a conditional add per bit of it.
// Configuration writes are taken only while the engine is idle.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [WORD_BITS-1:0]      i_cipher_word,
    output logic                      o_done,
    output logic [WORD_BITS-1:0]      o_plain_word,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]      i_cfg_data
);

    localparam int unsigned CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    // (x + y) mod m for x, y < m
    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] y,
        input logic [WORD_BITS-1:0] m
    );
        logic [WORD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    t_state                r_state, n_state;
    logic [WORD_BITS-1:0]  r_mod, r_exponent;
    logic [WORD_BITS-1:0]  r_acc, n_acc;
    logic [WORD_BITS-1:0]  r_sq, n_sq;
    logic [WORD_BITS-1:0]  r_exp, n_exp;
    logic [WORD_BITS-1:0]  r_bsh, n_bsh;
    logic [WORD_BITS-1:0]  r_ra, n_ra;
    logic [WORD_BITS-1:0]  r_rs, n_rs;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_phase, n_phase;
    logic                  r_done, n_done;
    logic [WORD_BITS-1:0]  r_result, n_result;

    logic                  start_ok;
    logic [WORD_BITS:0]    red_t;
    logic [WORD_BITS-1:0]  red_r;
    logic [WORD_BITS-1:0]  step_a, step_s;
    logic [WORD_BITS-1:0]  next_exp;

    assign o_busy       = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_done       = r_done;
    assign o_plain_word = r_result;
    assign start_ok     = i_start && !o_busy;

    // one compare-subtract per bit of the base
    assign red_t = {r_rs, r_bsh[WORD_BITS-1]};
    assign red_r = (red_t >= {1'b0, r_mod}) ? WORD_BITS'(red_t - {1'b0, r_mod})
                                            : red_t[WORD_BITS-1:0];

    // double on phase 0, add the multiplicand on phase 1 when the bit is set
    assign step_a = add_mod(r_ra, r_phase ? (r_bsh[WORD_BITS-1] ? r_acc : '0) : r_ra, r_mod);
    assign step_s = add_mod(r_rs, r_phase ? (r_bsh[WORD_BITS-1] ? r_sq : '0) : r_rs, r_mod);
    assign next_exp = r_exp >> 1;

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_sq     = r_sq;
        n_exp    = r_exp;
        n_bsh    = r_bsh;
        n_ra     = r_ra;
        n_rs     = r_rs;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (start_ok) begin
                    if (r_exponent == '0) begin
                        n_acc    = ONE;
                        n_result = ONE;
                        n_done   = 1'b1;
                    end else if (r_mod == '0) begin
                        n_acc    = '0;
                        n_result = '0;
                        n_done   = 1'b1;
                    end else begin
                        n_acc   = (r_mod == ONE) ? '0 : ONE;
                        n_exp   = r_exponent;
                        n_bsh   = i_cipher_word;
                        n_rs    = '0;
                        n_cnt   = '0;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                n_rs  = red_r;
                n_bsh = r_bsh << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_sq    = red_r;
                    n_bsh   = red_r;
                    n_ra    = '0;
                    n_rs    = '0;
                    n_cnt   = '0;
                    n_phase = 1'b0;
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                n_ra    = step_a;
                n_rs    = step_s;
                n_phase = !r_phase;
                if (r_phase) begin
                    n_bsh = r_bsh << 1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        // close one exponent bit
                        if (r_exp[0]) begin
                            n_acc = step_a;
                        end
                        n_sq  = step_s;
                        n_exp = next_exp;
                        n_bsh = step_s;
                        n_ra  = '0;
                        n_rs  = '0;
                        n_cnt = '0;
                        if (next_exp == '0) begin
                            n_result = r_exp[0] ? step_a : r_acc;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_mod      <= WORD_BITS'(77);
            r_exponent <= ONE;
            r_acc      <= '0;
            r_sq       <= '0;
            r_exp      <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_acc   <= n_acc;
            r_sq    <= n_sq;
            r_exp   <= n_exp;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODULUS:  r_mod      <= i_cfg_data;
                    CFG_EXPONENT: r_exponent <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bsh    <= n_bsh;
        r_ra     <= n_ra;
        r_rs     <= n_rs;
        r_cnt    <= n_cnt;
        r_phase  <= n_phase;
        r_result <= n_result;
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while engine busy");

    a_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start_ok && r_exponent == '0) |=> (o_done && o_plain_word == ONE))
        else $error("zero exponent did not give one");

    a_residues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULT) |-> (r_ra < r_mod && r_rs < r_mod && r_sq < r_mod
                                 && r_acc < r_mod))
        else $error("partial product left its residue range");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state == S_MULT) || $past(start_ok)))
        else $error("result strobe without a finished item");

endmodule

>>> dv/modexp_checker.sv
module modexp_checker
    import modexp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [WORD_BITS-1:0]      i_cipher_word,
    input  logic                      i_done,
    input  logic [WORD_BITS-1:0]      i_plain_word,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]      i_cfg_data,
    output int unsigned               o_pending,
    output int unsigned               o_mismatches
);

    localparam logic [WORD_BITS-1:0] MODULUS_AT_RESET  = WORD_BITS'(77);
    localparam logic [WORD_BITS-1:0] EXPONENT_AT_RESET = WORD_BITS'(1);
    localparam int unsigned          REPORT_LIMIT      = 10;

    typedef struct packed {
        logic [WORD_BITS-1:0] cipher;
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] exponent;
        logic [WORD_BITS-1:0] plain;
    } t_decryption;

    t_decryption          plain_due_q[$];
    logic [WORD_BITS-1:0] modulus_reg  = MODULUS_AT_RESET;
    logic [WORD_BITS-1:0] exponent_reg = EXPONENT_AT_RESET;
    int unsigned          mismatch_count = 0;

    // right-to-left square-and-multiply; both factors stay below the modulus,
    // so every product fits exactly in double width
    function automatic logic [WORD_BITS-1:0] mod_power(
        input logic [WORD_BITS-1:0] base_word,
        input logic [WORD_BITS-1:0] power,
        input logic [WORD_BITS-1:0] modulus
    );
        logic [2*WORD_BITS-1:0] product;
        logic [2*WORD_BITS-1:0] square;
        logic [2*WORD_BITS-1:0] wide_modulus;
        logic [WORD_BITS-1:0]   bits_left;
        if (power == '0)
            return WORD_BITS'(1);
        if (modulus == '0)
            return '0;
        wide_modulus = modulus;
        product      = (modulus == WORD_BITS'(1)) ? '0 : (2*WORD_BITS)'(1);
        square       = base_word % wide_modulus;
        bits_left    = power;
        while (bits_left != '0) begin
            if (bits_left[0])
                product = (product * square) % wide_modulus;
            square    = (square * square) % wide_modulus;
            bits_left = bits_left >> 1;
        end
        return product[WORD_BITS-1:0];
    endfunction

    function automatic void report(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : track
        t_decryption due;
        if (!i_rst_n) begin
            modulus_reg  = MODULUS_AT_RESET;
            exponent_reg = EXPONENT_AT_RESET;
            plain_due_q.delete();
        end else begin
            // retire before queuing, so a stray result never meets a fresh entry
            if (i_done !== 1'b0) begin
                if (plain_due_q.size() == 0) begin
                    report($sformatf("result %h with nothing outstanding", i_plain_word));
                end else begin
                    due = plain_due_q.pop_front();
                    if (i_plain_word !== due.plain)
                        report($sformatf(
                            "plain_word %h, expected %h (cipher %h modulus %h exponent %h)",
                            i_plain_word, due.plain, due.cipher, due.modulus, due.exponent));
                end
            end
            if (i_start && !i_busy) begin
                due.cipher   = i_cipher_word;
                due.modulus  = modulus_reg;
                due.exponent = exponent_reg;
                due.plain    = mod_power(i_cipher_word, exponent_reg, modulus_reg);
                plain_due_q  = {plain_due_q, due};
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODULUS:  modulus_reg  = i_cfg_data;
                    CFG_EXPONENT: exponent_reg = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= plain_due_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> dv/testbench.sv
module testbench;
    import modexp_pkg::*;

    localparam int unsigned WORD_BITS     = 32;
    localparam int unsigned RANDOM_PHASES = 11;
    localparam int unsigned PHASE_ITEMS   = 28;
    localparam int unsigned WIDE_ITEMS    = 8;
    localparam int unsigned SETTLE_CYCLES = 2200;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic [WORD_BITS-1:0]      cipher_word = '0;
    logic                      done;
    logic [WORD_BITS-1:0]      plain_word;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = CFG_MODULUS;
    logic [WORD_BITS-1:0]      cfg_data    = '0;
    int unsigned               pending;
    int unsigned               mismatches;
    logic [WORD_BITS-1:0]      modulus_now = 77;

    always #6 clk = ~clk;

    modular_exponentiation #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_cipher_word(cipher_word),
        .o_done       (done),
        .o_plain_word (plain_word),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    modexp_checker #(
        .WORD_BITS(WORD_BITS)
    ) decrypt_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cipher_word(cipher_word),
        .i_done       (done),
        .i_plain_word (plain_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // leaves start high, so back-to-back words need no gap
    task automatic decrypt(input logic [WORD_BITS-1:0] word);
        start       <= 1'b1;
        cipher_word <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // drop start and scribble on the data lines while idle
    task automatic pause_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) begin
            cipher_word <= $urandom();
            @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // leaves valid high; the caller drops it after the last transfer
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [WORD_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_key(input logic [WORD_BITS-1:0] modulus,
                           input logic [WORD_BITS-1:0] exponent,
                           input bit with_spare);
        wait_for_results();
        if (with_spare)
            write_register(CFG_SPARE, $urandom());
        write_register(CFG_MODULUS, modulus);
        write_register(CFG_EXPONENT, exponent);
        cfg_valid   <= 1'b0;
        modulus_now  = modulus;
    endtask

    function automatic logic [WORD_BITS-1:0] random_cipher();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(modulus_now - 1);
            2: return $urandom_range(0, 255);
            default: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 1;
                    2: return modulus_now - 1;
                    3: return modulus_now;
                    default: return ALL_ONES;
                endcase
            end
        endcase
    endfunction

    function automatic logic [WORD_BITS-1:0] random_modulus();
        case ($urandom_range(0, 4))
            0: return $urandom_range(2, 255);
            1: return $urandom_range(256, 65535);
            2: return $urandom() | 32'h8000_0000;
            3: return $urandom();
            default: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 1;
                    2: return 2;
                    default: return ALL_ONES;
                endcase
            end
        endcase
    endfunction

    initial begin : stimulus
        logic [WORD_BITS-1:0] exponent;
        int unsigned          items;
        bit                   steady;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register values out of reset
        decrypt(0);
        decrypt(76);
        decrypt(77);
        decrypt(78);
        decrypt(ALL_ONES);

        set_key(ALL_ONES, ALL_ONES, 1'b0);
        decrypt(0);
        decrypt(1);
        decrypt(ALL_ONES - 1);
        decrypt(ALL_ONES);

        // zero exponent wins over a degenerate modulus
        set_key(0, 0, 1'b0);
        decrypt(12345);
        decrypt(ALL_ONES);
        set_key(1, 0, 1'b0);
        decrypt(7);

        set_key(0, 3, 1'b0);
        decrypt(32'hDEAD_BEEF);
        set_key(1, ALL_ONES, 1'b0);
        decrypt(5);

        set_key(2, 2, 1'b0);
        decrypt(0);
        decrypt(1);
        decrypt(2);
        decrypt(3);

        // textbook key pair, cipher above the modulus on the second word
        set_key(3233, 2753, 1'b0);
        decrypt(2790);
        decrypt(3233 + 2790);

        set_key(32'h8000_0000, 32'h8000_0000, 1'b0);
        decrypt(2);
        decrypt(ALL_ONES);

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase % 4 == 3) begin
                exponent = $urandom() | 32'h8000_0000;
                items    = WIDE_ITEMS;
            end else begin
                case ($urandom_range(0, 7))
                    0:       exponent = '0;
                    1, 2, 3: exponent = $urandom_range(1, 255);
                    4:       exponent = $urandom_range(1, 15);
                    default: exponent = $urandom_range(256, 65535);
                endcase
                items = PHASE_ITEMS;
            end
            set_key(random_modulus(), exponent, phase == 2);
            steady = (phase == RANDOM_PHASES - 1);
            for (int unsigned n = 0; n < items; n++) begin
                if (!steady && $urandom_range(0, 2) == 0)
                    pause_sender($urandom_range(1, 18));
                decrypt(random_cipher());
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
src/modexp_pkg.sv
src/modular_exponentiation.sv
dv/modexp_checker.sv
dv/testbench.sv
